// File: sv/sirt_pkg.sv
// shared types, constants and helpers for the signed integer to radix text core
// used by the top level, the divide unit and the alphabet checker
package sirt_pkg;

	localparam int ValueW       = 32;
	localparam int RadixW       = 5;
	localparam int CharW        = 8;
	localparam int AlphaBytes   = 16;
	localparam int AlphaW       = AlphaBytes * CharW;
	localparam int MaxDigits    = 32;
	localparam int AddrW        = $clog2(MaxDigits);
	localparam int CountW       = AddrW + 1;
	localparam int DigitMaxW    = 4;
	localparam int DefMaxRadix  = 16;

	// divide unit retires this many quotient bits per cycle
	localparam int DivBitsPerStep = 8;
	localparam int DivSteps       = ValueW / DivBitsPerStep;
	localparam int DivStepW       = $clog2(DivSteps);

	localparam logic [CharW-1:0] ChMinus  = 8'h2d;
	localparam logic [CharW-1:0] WsLow    = 8'd9;
	localparam logic [CharW-1:0] WsHigh   = 8'd13;
	localparam logic [CharW-1:0] WsSpace  = 8'd32;

	typedef enum logic [1:0] {
		REG_RADIX      = 2'd0,
		REG_ALPHA_LOW  = 2'd1,
		REG_ALPHA_HIGH = 2'd2
	} sirt_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SIGN,
		ST_ZERO,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FETCH,
		ST_EMIT
	} sirt_state_t;

	// result of one division handed back to the sequencer
	typedef struct packed {
		logic                 done;
		logic [ValueW-1:0]    quotient;
		logic [DigitMaxW-1:0] remainder;
	} sirt_div_res_t;

	function automatic logic [CharW-1:0] alpha_byte(input logic [AlphaW-1:0] alph,
			input logic [DigitMaxW-1:0] k);
		return alph[k * CharW +: CharW];
	endfunction

endpackage

// File: sv/sirt_ram.sv
// generic single write port ram with registered read
// no dependencies
module sirt_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/sirt_alpha_check.sv
// alphabet checker: radix range, whitespace and repeated characters
// depends on sirt_pkg
module sirt_alpha_check import sirt_pkg::*; #(
	parameter int MAX_RADIX = DefMaxRadix
) (
	input  logic [RadixW-1:0] radix,
	input  logic [AlphaW-1:0] alphabet,
	output logic              ok
);

	always_comb begin
		logic             bad;
		logic [CharW-1:0] ci;
		bad = (radix < 5'd2) || (radix > RadixW'(MAX_RADIX));
		for (int i = 0; i < AlphaBytes; i++) begin
			ci = alpha_byte(alphabet, DigitMaxW'(i));
			if (RadixW'(i) < radix) begin
				if (((ci >= WsLow) && (ci <= WsHigh)) || (ci == WsSpace)) begin
					bad = 1'b1;
				end
				for (int j = i + 1; j < AlphaBytes; j++) begin
					if ((RadixW'(j) < radix) && (alpha_byte(alphabet, DigitMaxW'(j)) == ci)) begin
						bad = 1'b1;
					end
				end
			end
		end
		ok = !bad;
	end

endmodule

// File: sv/sirt_divider.sv
// iterative restoring divider, 32-bit dividend by a small radix
// eight quotient bits per cycle; depends on sirt_pkg
module sirt_divider import sirt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ValueW-1:0] dividend,
	input  logic [RadixW-1:0] divisor,
	output sirt_div_res_t     res
);

	logic [ValueW-1:0]    sh_q;
	logic [DigitMaxW-1:0] rem_q;
	logic [DivStepW-1:0]  step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ValueW-1:0]    sh_d;
	logic [DigitMaxW-1:0] rem_d;

	// eight shift-compare-subtract steps on the narrow remainder
	always_comb begin
		logic [RadixW-1:0] r;
		logic              ge;
		sh_d  = sh_q;
		rem_d = rem_q;
		for (int k = 0; k < DivBitsPerStep; k++) begin
			r     = {rem_d, sh_d[ValueW-1]};
			ge    = (r >= divisor);
			rem_d = ge ? DigitMaxW'(r - divisor) : DigitMaxW'(r);
			sh_d  = {sh_d[ValueW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == DivStepW'(DivSteps - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_d;
			rem_q <= rem_d;
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = sh_q;
	assign res.remainder = rem_q;

endmodule

// File: sv/signed_int_to_radix_text_core.sv
// top level: signed 32-bit integer to text in a configurable radix
// depends on sirt_pkg, sirt_ram, sirt_divider, sirt_alpha_check
//
// usage
//  - configuration: cfg_we writes cfg_data into register cfg_index (0 radix,
//    1 alphabet bytes 0..7, 2 alphabet bytes 8..15); write only while idle
//  - input channel: value with in_valid / in_stall; in_stall is high from the
//    accepting edge until the last character is registered or the item vanishes
//  - output channel: character and last_char with out_valid / out_stall, one
//    character per transfer, most significant digit first, a leading '-' for
//    negative values, last_char on the final character
//  - an invalid alphabet (radix below 2 or above MAX_RADIX, whitespace or a
//    repeated character among the first radix bytes) makes the item vanish
//  - sequence: the item is taken and checked, a '-' goes out for a negative
//    value, then each digit comes from the shared divider (start, 4 steps of
//    8 quotient bits, write-back), then each character is fetched through
//    the digit ram's registered read
//  - a stalled receiver holds the output register; the sequencer waits with
//    the next character until the register is free, nothing is dropped
//  - reset clears the configuration to zero and returns the sequencer to idle
module signed_int_to_radix_text_core import sirt_pkg::*; #(
	parameter int MAX_RADIX = DefMaxRadix
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	// input items
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ValueW-1:0] value,
	// result items
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CharW-1:0]  character,
	output logic              last_char
);

	// digit index width follows the largest radix
	localparam int DigW = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;

	// configuration registers
	logic [RadixW-1:0] radix_q;
	logic [63:0]       alpha_lo_q;
	logic [63:0]       alpha_hi_q;
	logic [AlphaW-1:0] alphabet;

	// sequencer state
	sirt_state_t       state_q, state_d;
	logic [ValueW-1:0] value_q;
	logic [ValueW-1:0] mag_q;
	logic [CountW-1:0] cnt_q;
	logic [CountW-1:0] ptr_q;

	// output register
	logic              out_valid_q;
	logic [CharW-1:0]  char_q;
	logic              last_q;
	logic              slot_free;

	// control decoded from the state
	logic              div_start;
	logic              load_out;
	logic [CharW-1:0]  load_char;
	logic              load_last;

	logic              alpha_ok;
	sirt_div_res_t     div_res;
	logic              dig_last;
	logic [AddrW-1:0]  raddr;
	logic [DigW-1:0]   ram_rdata;

	assign alphabet  = {alpha_hi_q, alpha_lo_q};
	assign slot_free = !out_valid_q || !out_stall;
	// last digit when the quotient runs out or the buffer is full
	assign dig_last  = (div_res.quotient == '0) || (cnt_q == CountW'(MaxDigits - 1));
	assign raddr     = AddrW'(ptr_q - 1'b1);

	sirt_alpha_check #(
		.MAX_RADIX(MAX_RADIX)
	) u_check (
		.radix   (radix_q),
		.alphabet(alphabet),
		.ok      (alpha_ok)
	);

	sirt_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag_q),
		.divisor (radix_q),
		.res     (div_res)
	);

	// digit buffer, least significant digit at address 0
	sirt_ram #(
		.WIDTH(DigW),
		.DEPTH(MaxDigits)
	) u_digits (
		.clk  (clk),
		.we   ((state_q == ST_DIV_WAIT) && div_res.done),
		.waddr(cnt_q[AddrW-1:0]),
		.wdata(div_res.remainder[DigW-1:0]),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= '0;
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIX:      radix_q    <= cfg_data[RadixW-1:0];
				REG_ALPHA_LOW:  alpha_lo_q <= cfg_data;
				REG_ALPHA_HIGH: alpha_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!alpha_ok) state_d = ST_IDLE;
				else if (value_q[ValueW-1]) state_d = ST_SIGN;
				else if (value_q == '0) state_d = ST_ZERO;
				else state_d = ST_DIV_GO;
			end
			ST_SIGN: begin
				if (slot_free) state_d = ST_DIV_GO;
			end
			ST_ZERO: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_DIV_GO: begin
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_res.done) state_d = dig_last ? ST_FETCH : ST_DIV_GO;
			end
			ST_FETCH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) state_d = (ptr_q == CountW'(1)) ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = (state_q == ST_DIV_GO);
		load_out  = 1'b0;
		load_char = alpha_byte(alphabet, DigitMaxW'(ram_rdata));
		load_last = 1'b0;
		unique case (state_q)
			ST_SIGN: begin
				load_out  = slot_free;
				load_char = ChMinus;
			end
			ST_ZERO: begin
				load_out  = slot_free;
				load_char = alpha_byte(alphabet, '0);
				load_last = 1'b1;
			end
			ST_EMIT: begin
				load_out  = slot_free;
				load_last = (ptr_q == CountW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				cnt_q <= '0;
			end else if ((state_q == ST_DIV_WAIT) && div_res.done) begin
				cnt_q <= cnt_q + 1'b1;
				if (dig_last) ptr_q <= cnt_q + 1'b1;
			end else if ((state_q == ST_EMIT) && slot_free) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			value_q <= value;
		end
		if (state_q == ST_CHECK) begin
			mag_q <= value_q[ValueW-1] ? (~value_q + 1'b1) : value_q;
		end else if ((state_q == ST_DIV_WAIT) && div_res.done) begin
			mag_q <= div_res.quotient;
		end
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule
